// ----- hdl/cctx_pkg.sv -----
package cctx_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int CFG_W          = 11;
    localparam int CID_W          = 16;
    localparam int STAT_W         = 2;
    localparam int IDX_OUT_W      = 10;
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 11'd64;

    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_FOUND    = 2'd0,
        STAT_NEW      = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RELEASED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Result of comparing one slot, merged with the free slot seen so far.
    typedef struct packed {
        logic                 hit;
        logic                 have_free;
        logic [IDX_OUT_W-1:0] free_idx;
    } t_scan_res;

endpackage

// ----- hdl/cctx_ram.sv -----
module cctx_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/cctx_scan.sv -----
module cctx_scan (
    input  logic                                i_clk,
    input  logic                                i_clear,
    input  logic                                i_vld,
    input  logic [cctx_pkg::IDX_OUT_W-1:0]      i_idx,
    input  logic                                i_used,
    input  logic [cctx_pkg::CID_W-1:0]          i_client,
    input  logic [cctx_pkg::CID_W-1:0]          i_cid,
    output cctx_pkg::t_scan_res                 o_res
);

    logic                           r_have_free;
    logic [cctx_pkg::IDX_OUT_W-1:0] r_free_idx;
    logic                           is_free;

    // The scan runs upward, so the last free slot seen is the highest one.
    assign is_free         = i_vld && !i_used;
    assign o_res.hit       = i_vld && i_used && (i_client == i_cid);
    assign o_res.have_free = r_have_free || is_free;
    assign o_res.free_idx  = is_free ? i_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_have_free <= 1'b0;
        end else if (is_free) begin
            r_have_free <= 1'b1;
        end
        if (is_free) begin
            r_free_idx <= i_idx;
        end
    end

endmodule

// ----- hdl/client_context_slot_table_unit.sv -----
// Channel        | Direction | Ports                                   | Handshake
// ---------------+-----------+-----------------------------------------+------------------------
// request        | in        | i_opcode, i_client_id                   | i_start while !o_busy
// result         | out       | o_status, o_slot_index                  | o_done, one cycle
// configuration  | in        | i_cfg_wdata (slots_in_use)              | i_cfg_we
//
// A get transaction reads the active slots from the slot memory one per cycle and
// compares each one in the shared compare unit; it keeps the block busy until a hit or
// the last active slot is compared, and the result strobe rises in the same cycle as o_busy falls.
// A release-all transaction sweeps every built slot with one memory write each.
// After reset the same sweep runs to clear the used flags, and no request is taken
// meanwhile; configuration writes are accepted at any time.
// The receiver cannot stall, so each result is presented for exactly one cycle.
module client_context_slot_table_unit #(
    parameter int SLOT_COUNT = cctx_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_opcode,
    input  logic [cctx_pkg::CID_W-1:0]        i_client_id,
    output logic                              o_done,
    output logic [cctx_pkg::STAT_W-1:0]       o_status,
    output logic [cctx_pkg::IDX_OUT_W-1:0]    o_slot_index,
    input  logic                              i_cfg_we,
    input  logic [cctx_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int MEM_W = cctx_pkg::CID_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    // Control registers.
    cctx_pkg::t_state            r_state, n_state;
    logic [cctx_pkg::CFG_W-1:0]  r_slots_in_use;
    logic                        r_more, n_more;
    logic                        r_pend, n_pend;
    logic                        r_clr_report, n_clr_report;
    logic                        r_done, n_done;

    // Payload registers.
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [IDX_W-1:0]            r_last_idx, n_last_idx;
    logic [IDX_W-1:0]            r_pend_idx, n_pend_idx;
    logic                        r_pend_last, n_pend_last;
    logic [CNT_W-1:0]            r_active, n_active_reg;
    logic [cctx_pkg::CID_W-1:0]  r_cid, n_cid;
    cctx_pkg::t_status           r_status, n_status;
    logic [cctx_pkg::IDX_OUT_W-1:0] r_slot_index, n_slot_index;

    // Slot memory: bit CID_W is the used flag, the rest is the stored client.
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [MEM_W-1:0]            mem_wdata;
    logic [IDX_W-1:0]            mem_raddr;
    logic [MEM_W-1:0]            mem_rdata;

    logic [CNT_W-1:0]            n_active;
    logic                        accept;
    cctx_pkg::t_scan_res         scan_res;

    // The active count saturates at the built slot count.
    assign n_active = (r_slots_in_use > cctx_pkg::CFG_W'(SLOT_COUNT)) ?
                      CNT_W'(SLOT_COUNT) : CNT_W'(r_slots_in_use);

    assign accept = i_start && (r_state == cctx_pkg::ST_IDLE);

    cctx_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The compare unit looks at the slot whose read was issued in the previous cycle.
    cctx_scan u_scan (
        .i_clk    (i_clk),
        .i_clear  (accept),
        .i_vld    (r_pend && (r_state == cctx_pkg::ST_SCAN)),
        .i_idx    (cctx_pkg::IDX_OUT_W'(r_pend_idx)),
        .i_used   (mem_rdata[cctx_pkg::CID_W]),
        .i_client (mem_rdata[cctx_pkg::CID_W-1:0]),
        .i_cid    (r_cid),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cctx_pkg::ST_CLEAR;
            r_slots_in_use <= cctx_pkg::SLOTS_IN_USE_RST;
            r_more         <= 1'b0;
            r_pend         <= 1'b0;
            r_clr_report   <= 1'b0;
            r_done         <= 1'b0;
            r_idx          <= '0;
        end else begin
            r_state      <= n_state;
            r_more       <= n_more;
            r_pend       <= n_pend;
            r_clr_report <= n_clr_report;
            r_done       <= n_done;
            r_idx        <= n_idx;
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx   <= n_last_idx;
        r_pend_idx   <= n_pend_idx;
        r_pend_last  <= n_pend_last;
        r_active     <= n_active_reg;
        r_cid        <= n_cid;
        r_status     <= n_status;
        r_slot_index <= n_slot_index;
    end

    always_comb begin
        n_state      = r_state;
        n_more       = r_more;
        n_pend       = 1'b0;
        n_clr_report = r_clr_report;
        n_done       = 1'b0;
        n_idx        = r_idx;
        n_last_idx   = r_last_idx;
        n_pend_idx   = r_pend_idx;
        n_pend_last  = r_pend_last;
        n_active_reg = r_active;
        n_cid        = r_cid;
        n_status     = r_status;
        n_slot_index = r_slot_index;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = '0;
        mem_raddr    = r_idx;

        case (r_state)
            cctx_pkg::ST_CLEAR: begin
                // Sweep every built slot and clear its used flag.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = '0;
                n_idx     = r_idx + 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_idx        = '0;
                    n_state      = cctx_pkg::ST_IDLE;
                    n_clr_report = 1'b0;
                    if (r_clr_report) begin
                        n_done       = 1'b1;
                        n_status     = cctx_pkg::STAT_RELEASED;
                        n_slot_index = '0;
                    end
                end
            end

            cctx_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_idx = '0;
                    if (i_opcode == cctx_pkg::OP_RELEASE) begin
                        n_state      = cctx_pkg::ST_CLEAR;
                        n_clr_report = 1'b1;
                    end else if (n_active == '0) begin
                        // Nothing is searched, so there is never a free slot.
                        n_done       = 1'b1;
                        n_status     = cctx_pkg::STAT_FULL;
                        n_slot_index = '0;
                    end else begin
                        n_state      = cctx_pkg::ST_SCAN;
                        n_more       = 1'b1;
                        n_cid        = i_client_id;
                        n_active_reg = n_active;
                        n_last_idx   = IDX_W'(n_active - 1'b1);
                    end
                end
            end

            cctx_pkg::ST_SCAN: begin
                // Issue the next read while the previous slot is compared.
                if (r_more) begin
                    mem_raddr   = r_idx;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_idx;
                    n_pend_last = (r_idx == r_last_idx);
                    n_more      = (r_idx != r_last_idx);
                    n_idx       = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (scan_res.hit) begin
                        n_state      = cctx_pkg::ST_IDLE;
                        n_more       = 1'b0;
                        n_pend       = 1'b0;
                        n_done       = 1'b1;
                        n_status     = cctx_pkg::STAT_FOUND;
                        n_slot_index = cctx_pkg::IDX_OUT_W'(r_pend_idx);
                    end else if (r_pend_last) begin
                        n_state = cctx_pkg::ST_IDLE;
                        n_more  = 1'b0;
                        n_pend  = 1'b0;
                        n_done  = 1'b1;
                        if (scan_res.have_free) begin
                            // Claim the highest free slot for this client.
                            mem_we       = 1'b1;
                            mem_waddr    = scan_res.free_idx[IDX_W-1:0];
                            mem_wdata    = {1'b1, r_cid};
                            n_status     = cctx_pkg::STAT_NEW;
                            n_slot_index = scan_res.free_idx;
                        end else begin
                            n_status     = cctx_pkg::STAT_FULL;
                            n_slot_index = '0;
                        end
                    end
                end
            end

            default: begin
                n_state = cctx_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy       = (r_state != cctx_pkg::ST_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_index = r_slot_index;

    // A result is only strobed once the block is ready again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while busy");

    // A get with active slots always starts a scan.
    a_get_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == cctx_pkg::OP_GET) && (n_active != '0)) |=> o_busy)
        else $error("get did not start a scan");

    // A found or new slot lies inside the active range of the scan.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == cctx_pkg::STAT_FOUND) || (o_status == cctx_pkg::STAT_NEW)))
        |-> ({1'b0, o_slot_index} < cctx_pkg::CFG_W'(r_active)))
        else $error("slot index outside active range");

    // No-space and release results carry index zero.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == cctx_pkg::STAT_FULL) ||
                    (o_status == cctx_pkg::STAT_RELEASED))) |-> (o_slot_index == '0))
        else $error("nonzero index on no-space or release result");

    // An allocation write happens only when a free slot was seen.
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == cctx_pkg::ST_SCAN)) |-> scan_res.have_free)
        else $error("allocation without a free slot");

endmodule

// ----- sim/cctx_slot_checker.sv -----
module cctx_slot_checker
    import cctx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_opcode,
    input  logic [CID_W-1:0]     i_client_id,
    input  logic                 i_done,
    input  logic [STAT_W-1:0]    i_status,
    input  logic [IDX_OUT_W-1:0] i_slot_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] slot_index;
    } t_lookup;

    logic             model_used   [SLOT_COUNT];
    logic [CID_W-1:0] model_client [SLOT_COUNT];
    logic [CFG_W-1:0] model_slots;
    t_lookup          expected_lookups [$];
    t_lookup          oldest;
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    // Mirrors one request against the local copy of the table and returns its result.
    function automatic t_lookup lookup_or_claim(input logic op, input logic [CID_W-1:0] cid);
        t_lookup r;
        int      active;
        int      free_slot;
        bit      have_free;
        r.status     = STAT_RELEASED;
        r.slot_index = '0;
        free_slot    = 0;
        have_free    = 1'b0;
        if (op == OP_RELEASE) begin
            for (int i = 0; i < SLOT_COUNT; i++) model_used[i] = 1'b0;
            return r;
        end
        active = (model_slots > SLOT_COUNT) ? SLOT_COUNT : int'(model_slots);
        for (int i = 0; i < active; i++) begin
            if (model_used[i]) begin
                if (model_client[i] == cid) begin
                    r.status     = STAT_FOUND;
                    r.slot_index = IDX_OUT_W'(i);
                    return r;
                end
            end else begin
                free_slot = i;
                have_free = 1'b1;
            end
        end
        if (have_free) begin
            model_used[free_slot]   = 1'b1;
            model_client[free_slot] = cid;
            r.status     = STAT_NEW;
            r.slot_index = IDX_OUT_W'(free_slot);
        end else begin
            r.status = STAT_FULL;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                model_used[i]   = 1'b0;
                model_client[i] = '0;
            end
            model_slots = SLOTS_IN_USE_RST;
            expected_lookups.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (expected_lookups.size() == 0) begin
                    note_mismatch($sformatf("result status %0d index %0d with no request open",
                                            i_status, i_slot_index));
                end else begin
                    oldest = expected_lookups.pop_front();
                    if (i_status !== oldest.status)
                        note_mismatch($sformatf("status expected %s got %0d",
                                                oldest.status.name(), i_status));
                    if (i_slot_index !== oldest.slot_index)
                        note_mismatch($sformatf("slot_index expected %0d got %0d",
                                                oldest.slot_index, i_slot_index));
                end
            end
            // A request taken at the same edge as a register write still sees the old count.
            if (i_start === 1'b1 && i_busy === 1'b0)
                expected_lookups.push_back(lookup_or_claim(i_opcode, i_client_id));
            if (i_cfg_we === 1'b1) model_slots = i_cfg_wdata;
        end
        o_pending <= expected_lookups.size();
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import cctx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The table is built at its default size; the checker is told the same size.
    localparam int SLOTS        = SLOT_COUNT_DEF;
    // Total random transactions, and the tail of them that runs without any idling.
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_TAIL   = 150;
    localparam int PHASES       = 10;
    // The slowest correct run is roughly 1200 transactions, each a full scan followed by
    // the longest idle gap; the watchdog limit allows several times that run.
    localparam int CYCLE_LIMIT  = 600000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    logic                 i_opcode    = OP_GET;
    logic [CID_W-1:0]     i_client_id = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [STAT_W-1:0]    o_status;
    logic [IDX_OUT_W-1:0] o_slot_index;

    int pending_results;
    int fail_count;
    int cycle_count = 0;

    client_context_slot_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_client_id (i_client_id),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_slot_index(o_slot_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // The checker sits beside the block, watches both channels and the
    // configuration port, predicts each result and compares it.
    cctx_slot_checker #(
        .SLOT_COUNT(SLOTS)
    ) slot_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_client_id (i_client_id),
        .i_done      (o_done),
        .i_status    (o_status),
        .i_slot_index(o_slot_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending_results),
        .o_fail_count(fail_count)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("client_context_slot_table_unit verification failed");
            $finish;
        end
    end

    // Presents one request and returns at the edge that accepts it. The request
    // stays on the ports, so a following transaction can go out back to back
    // without start being lowered in between. Outputs read right after an edge
    // still hold their values from before that edge.
    task automatic send_request(input logic op, input logic [CID_W-1:0] cid);
        i_start     <= 1'b1;
        i_opcode    <= op;
        i_client_id <= cid;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Writes slots_in_use only once every open transaction has produced its
    // result and the block has had time to settle back to idle.
    task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_cfg [8];
        logic [CID_W-1:0] id_pool [80];
        logic [CFG_W-1:0] slots_cfg;
        int               active;
        int               pool_size;
        int               per_phase;
        int               item_no;
        int               pick;
        bit               idle_on;
        bit               quiet;

        phase_cfg = '{11'd3, 11'd64, 11'd2047, 11'd1,
                      11'd0, 11'd1024, 11'd16, 11'd65};
        item_no   = 0;
        per_phase = RANDOM_ITEMS / PHASES;

        // Reset is held at the start; the block then clears its used flags and
        // stays busy meanwhile, which the first handshake simply waits out.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting of 64 active slots. Allocation goes
        // from the top slot downward, and a repeated client is found again.
        send_request(OP_GET, 16'h0000);
        send_request(OP_GET, 16'hFFFF);
        send_request(OP_GET, 16'h0000);
        send_request(OP_GET, 16'hFFFF);
        send_request(OP_GET, 16'h5555);
        send_request(OP_GET, 16'hAAAA);
        // Release-all clears every slot word, used flag and client alike, so the
        // same client afterward gets a fresh allocation rather than a hit.
        send_request(OP_RELEASE, 16'hFFFF);
        send_request(OP_GET, 16'hFFFF);

        // One active slot: it fills at once, and the next new client is refused.
        write_slots_in_use(11'd1);
        send_request(OP_GET, 16'h1234);
        send_request(OP_GET, 16'h1234);
        send_request(OP_GET, 16'h4321);

        // With no slot searched every get reports that there is no space.
        write_slots_in_use(11'd0);
        send_request(OP_GET, 16'h1234);
        send_request(OP_GET, 16'h0000);

        // The largest register value saturates at the built slot count.
        write_slots_in_use(11'd2047);
        send_request(OP_GET, 16'h1234);
        send_request(OP_GET, 16'hFFFF);
        send_request(OP_GET, 16'h8001);

        // Two active slots: fill both, overflow, release and refill.
        write_slots_in_use(11'd2);
        send_request(OP_GET, 16'h0F0F);
        send_request(OP_GET, 16'hF0F0);
        send_request(OP_GET, 16'h7FFE);
        send_request(OP_RELEASE, 16'h0000);
        send_request(OP_GET, 16'h7FFE);

        // Random part. Each phase picks a slot count, extremes first, and draws
        // clients mostly from a small pool so that hits, fills and refusals all
        // happen often. The rest is release-all and clients taken at random.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 8)
                slots_cfg = phase_cfg[phase];
            else if (phase == 8)
                slots_cfg = CFG_W'($urandom_range(1, SLOTS));
            else
                slots_cfg = CFG_W'($urandom_range(0, 2047));
            write_slots_in_use(slots_cfg);

            active    = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
            pool_size = $urandom_range(1, active + 8);
            if (pool_size > 80) pool_size = 80;
            for (int k = 0; k < pool_size; k++) id_pool[k] = CID_W'($urandom);
            // Some phases run with no idling at all.
            idle_on = ($urandom_range(0, 2) != 0);

            for (int k = 0; k < per_phase; k++) begin
                item_no++;
                quiet = (item_no > RANDOM_ITEMS - QUIET_TAIL);
                pick  = $urandom_range(0, 99);
                if (pick < 4)
                    send_request(OP_RELEASE, CID_W'($urandom));
                else if (pick < 82)
                    send_request(OP_GET, id_pool[$urandom_range(0, pool_size - 1)]);
                else
                    send_request(OP_GET, CID_W'($urandom));
                // Start is lowered for a burst of idle cycles at random points, so
                // the gaps fall while the block is scanning as well as when idle.
                if (!quiet && idle_on && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 16));
            end
        end

        // Drain: wait for every open transaction, then allow a full sweep more so
        // that a stray late result would still be caught.
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("client_context_slot_table_unit verification clean");
        end else begin
            $display("client_context_slot_table_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- client_context_slot_table_unit.f -----
hdl/cctx_pkg.sv
hdl/cctx_ram.sv
hdl/cctx_scan.sv
hdl/client_context_slot_table_unit.sv
sim/cctx_slot_checker.sv
sim/tb_top.sv
